// ===== hw/rtl/psm_pkg.sv =====
package psm_pkg;

  localparam int TimeBits    = 36;
  localparam int TimerBits   = TimeBits + 1;
  localparam int DtBits      = 32;
  localparam int CurBits     = 20;
  localparam int CountBits   = 32;
  localparam int PhaseBits   = 2;
  localparam int CfgDataBits = 64;
  localparam int RegIdxBits  = 3;
  localparam int AddrLsb     = 3;
  localparam int CfgAddrBits = RegIdxBits + AddrLsb;

  localparam logic [TimeBits-1:0] ActiveTimerRst    = TimeBits'(64'd10000);
  localparam logic [TimeBits-1:0] PeriodicUpdateRst = TimeBits'(64'd86400000);
  localparam logic [TimeBits-1:0] UpdateDurationRst = TimeBits'(64'd2000);
  localparam logic [CurBits-1:0]  SleepCurrentRst   = CurBits'(3);
  localparam logic [CurBits-1:0]  IdleCurrentRst    = CurBits'(5000);
  localparam logic [CurBits-1:0]  BusyCurrentRst    = CurBits'(50000);
  localparam logic [CurBits-1:0]  UpdateCurrentRst  = CurBits'(200000);

  typedef enum logic [RegIdxBits-1:0] {
    RegActiveTimer    = 3'd0,
    RegPeriodicUpdate = 3'd1,
    RegUpdateDuration = 3'd2,
    RegSleepCurrent   = 3'd3,
    RegIdleCurrent    = 3'd4,
    RegBusyCurrent    = 3'd5,
    RegUpdateCurrent  = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    PhActive      = 4'b0001,
    PhActiveTimer = 4'b0010,
    PhSleep       = 4'b0100,
    PhUpdate      = 4'b1000
  } phase_e;

  localparam logic [PhaseBits-1:0] PhaseCodeActive      = 2'd0;
  localparam logic [PhaseBits-1:0] PhaseCodeActiveTimer = 2'd1;
  localparam logic [PhaseBits-1:0] PhaseCodeSleep       = 2'd2;
  localparam logic [PhaseBits-1:0] PhaseCodeUpdate      = 2'd3;

  typedef struct packed {
    logic [DtBits-1:0] dt_ms;
  } in_t;

  typedef struct packed {
    logic [PhaseBits-1:0] phase_out;
    logic [CurBits-1:0]   current_ua;
    logic [CountBits-1:0] update_total;
  } out_t;

  typedef struct packed {
    logic [TimeBits-1:0] active_timer_ms;
    logic [TimeBits-1:0] periodic_update_ms;
    logic [TimeBits-1:0] update_duration_ms;
    logic [CurBits-1:0]  doze_current_ua;
    logic [CurBits-1:0]  idle_current_ua;
    logic [CurBits-1:0]  busy_current_ua;
    logic [CurBits-1:0]  update_current_ua;
  } cfg_t;

endpackage

// ===== hw/rtl/psm_stream_if.sv =====
interface psm_in_if import psm_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psm_out_if import psm_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/psm_cfg_regs.sv =====
module psm_cfg_regs import psm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [CfgDataBits-1:0] pwdata,
  output logic [CfgDataBits-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrLsb +: RegIdxBits]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegActiveTimer:    cfg_d.active_timer_ms    = pwdata[TimeBits-1:0];
        RegPeriodicUpdate: cfg_d.periodic_update_ms = pwdata[TimeBits-1:0];
        RegUpdateDuration: cfg_d.update_duration_ms = pwdata[TimeBits-1:0];
        RegSleepCurrent:   cfg_d.doze_current_ua    = pwdata[CurBits-1:0];
        RegIdleCurrent:    cfg_d.idle_current_ua    = pwdata[CurBits-1:0];
        RegBusyCurrent:    cfg_d.busy_current_ua    = pwdata[CurBits-1:0];
        RegUpdateCurrent:  cfg_d.update_current_ua  = pwdata[CurBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegActiveTimer:    prdata = CfgDataBits'(cfg_q.active_timer_ms);
      RegPeriodicUpdate: prdata = CfgDataBits'(cfg_q.periodic_update_ms);
      RegUpdateDuration: prdata = CfgDataBits'(cfg_q.update_duration_ms);
      RegSleepCurrent:   prdata = CfgDataBits'(cfg_q.doze_current_ua);
      RegIdleCurrent:    prdata = CfgDataBits'(cfg_q.idle_current_ua);
      RegBusyCurrent:    prdata = CfgDataBits'(cfg_q.busy_current_ua);
      RegUpdateCurrent:  prdata = CfgDataBits'(cfg_q.update_current_ua);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_timer_ms    <= ActiveTimerRst;
      cfg_q.periodic_update_ms <= PeriodicUpdateRst;
      cfg_q.update_duration_ms <= UpdateDurationRst;
      cfg_q.doze_current_ua    <= SleepCurrentRst;
      cfg_q.idle_current_ua    <= IdleCurrentRst;
      cfg_q.busy_current_ua    <= BusyCurrentRst;
      cfg_q.update_current_ua  <= UpdateCurrentRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/psm_phase_fsm.sv =====
module psm_phase_fsm import psm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [DtBits-1:0] dt_i,
  input  cfg_t              cfg_i,
  output out_t              result_o
);

  localparam int SumBits = ((TimerBits > DtBits) ? TimerBits : DtBits) + 1;

  phase_e                phase_q, phase_d;
  logic [TimerBits-1:0]  short_timer_q, short_timer_d;
  logic [TimerBits-1:0]  long_timer_q, long_timer_d;
  logic [CountBits-1:0]  update_count_q, update_count_d;
  logic [TimerBits-1:0]  short_sum;
  logic [TimerBits-1:0]  long_sum;

  function automatic logic [TimerBits-1:0] sat_add(logic [TimerBits-1:0] t,
                                                    logic [DtBits-1:0] dt);
    logic [SumBits-1:0] s;
    s = SumBits'(t) + SumBits'(dt);
    if (s[SumBits-1:TimerBits] != '0) begin
      return '1;
    end
    return s[TimerBits-1:0];
  endfunction

  assign short_sum = sat_add(short_timer_q, dt_i);
  assign long_sum  = sat_add(long_timer_q, dt_i);

  always_comb begin
    phase_d        = phase_q;
    short_timer_d  = short_timer_q;
    long_timer_d   = long_timer_q;
    update_count_d = update_count_q;
    if (dt_i != '0) begin
      case (phase_q)
        PhActive: begin
          phase_d       = PhActiveTimer;
          short_timer_d = '0;
          long_timer_d  = '0;
        end
        PhActiveTimer: begin
          short_timer_d = short_sum;
          long_timer_d  = long_sum;
          if (short_sum >= TimerBits'(cfg_i.active_timer_ms)) begin
            phase_d       = PhSleep;
            short_timer_d = '0;
          end
        end
        PhSleep: begin
          long_timer_d = long_sum;
          if (long_sum >= TimerBits'(cfg_i.periodic_update_ms)) begin
            phase_d      = PhUpdate;
            long_timer_d = '0;
          end
        end
        default: begin
          short_timer_d = short_sum;
          if (short_sum >= TimerBits'(cfg_i.update_duration_ms)) begin
            phase_d        = PhActive;
            update_count_d = update_count_q + CountBits'(1);
            short_timer_d  = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    result_o.update_total = update_count_d;
    case (phase_d)
      PhActive: begin
        result_o.phase_out  = PhaseCodeActive;
        result_o.current_ua = cfg_i.busy_current_ua;
      end
      PhActiveTimer: begin
        result_o.phase_out  = PhaseCodeActiveTimer;
        result_o.current_ua = cfg_i.idle_current_ua;
      end
      PhSleep: begin
        result_o.phase_out  = PhaseCodeSleep;
        result_o.current_ua = cfg_i.doze_current_ua;
      end
      default: begin
        result_o.phase_out  = PhaseCodeUpdate;
        result_o.current_ua = cfg_i.update_current_ua;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhActive;
      short_timer_q  <= '0;
      long_timer_q   <= '0;
      update_count_q <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      short_timer_q  <= short_timer_d;
      long_timer_q   <= long_timer_d;
      update_count_q <= update_count_d;
    end
  end

  // zero tick leaves phase and count alone
  a_zero_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && dt_i == '0) |=> ($stable(phase_q) && $stable(update_count_q)))
    else $error("zero tick changed state");

  a_no_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(update_count_q) && $stable(short_timer_q) && $stable(long_timer_q)))
    else $error("state moved without a transfer");

  a_active_timers_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhActive) |-> (short_timer_q == '0 && long_timer_q == '0))
    else $error("timers not clear in active phase");

  a_sleep_short_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSleep) |-> (short_timer_q == '0))
    else $error("short timer running in sleep");

  a_update_long_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhUpdate) |-> (long_timer_q == '0))
    else $error("long timer running in update");

endmodule

// ===== hw/rtl/psm_timer_state_machine_core.sv =====
// channel  | dir | payload                                | transfer when
// ---------+-----+----------------------------------------+----------------------------
// in_i     | in  | dt_ms                                  | valid && ready
// out_o    | out | phase_out, current_ua, update_total    | valid && ready
// apb      | in  | 7 registers at paddr 8*i, 64-bit data  | psel && penable && pwrite
//
// one item per cycle sustained while the output is not stalled; a result is registered in
// stage two from the input held in stage one, and waits there until the output takes it
// stage one is the input register, stage two the result register; the phase
// state advances as an item moves from stage one to stage two
// reset clears the phase to active, both timers and the update count
// a stalled output holds its result while one more input is taken into stage one
module psm_timer_state_machine_core import psm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  psm_in_if.sink                 in_i,
  psm_out_if.source              out_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [CfgDataBits-1:0] pwdata,
  output logic [CfgDataBits-1:0] prdata,
  output logic                   pready
);

  cfg_t              cfg;
  out_t              result;
  logic              in_valid_q, in_valid_d;
  logic [DtBits-1:0] in_dt_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q;
  logic              out_free;
  logic              advance;
  logic              in_fire;

  psm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  psm_phase_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .dt_i     (in_dt_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_dt_q <= in_i.data.dt_ms;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== dv/psm_result_checker.sv =====
`timescale 1ns / 1ps

module psm_result_checker import psm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  in_t                    in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  out_t                   out_data_i,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic                   pready_i,
  input  logic [CfgAddrBits-1:0] paddr_i,
  input  logic [CfgDataBits-1:0] pwdata_i,
  output int                     pending_o,
  output int                     fails_o
);

  cfg_t                 cfg;
  logic [PhaseBits-1:0] phase_q;
  logic [TimerBits-1:0] short_ms;
  logic [TimerBits-1:0] long_ms;
  logic [CountBits-1:0] updates;
  out_t                 expected_results[$];

  function automatic logic [TimerBits-1:0] sat_add(input logic [TimerBits-1:0] t,
                                                   input logic [DtBits-1:0] dt);
    logic [TimerBits:0] sum;
    sum = {1'b0, t} + (TimerBits + 1)'(dt);
    return sum[TimerBits] ? '1 : sum[TimerBits-1:0];
  endfunction

  function automatic out_t advance_phase(input logic [DtBits-1:0] dt);
    out_t res;
    if (dt != '0) begin
      case (phase_q)
        PhaseCodeActive: begin
          phase_q  = PhaseCodeActiveTimer;
          short_ms = '0;
          long_ms  = '0;
        end
        PhaseCodeActiveTimer: begin
          short_ms = sat_add(short_ms, dt);
          long_ms  = sat_add(long_ms, dt);
          if (short_ms >= cfg.active_timer_ms) begin
            phase_q  = PhaseCodeSleep;
            short_ms = '0;
          end
        end
        PhaseCodeSleep: begin
          long_ms = sat_add(long_ms, dt);
          if (long_ms >= cfg.periodic_update_ms) begin
            phase_q = PhaseCodeUpdate;
            long_ms = '0;
          end
        end
        PhaseCodeUpdate: begin
          short_ms = sat_add(short_ms, dt);
          if (short_ms >= cfg.update_duration_ms) begin
            phase_q  = PhaseCodeActive;
            updates  = updates + 1'b1;
            short_ms = '0;
          end
        end
        default: ;
      endcase
    end
    res.phase_out = phase_q;
    case (phase_q)
      PhaseCodeActive:      res.current_ua = cfg.busy_current_ua;
      PhaseCodeActiveTimer: res.current_ua = cfg.idle_current_ua;
      PhaseCodeSleep:       res.current_ua = cfg.doze_current_ua;
      default:              res.current_ua = cfg.update_current_ua;
    endcase
    res.update_total = updates;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      cfg.active_timer_ms    = ActiveTimerRst;
      cfg.periodic_update_ms = PeriodicUpdateRst;
      cfg.update_duration_ms = UpdateDurationRst;
      cfg.doze_current_ua    = SleepCurrentRst;
      cfg.idle_current_ua    = IdleCurrentRst;
      cfg.busy_current_ua    = BusyCurrentRst;
      cfg.update_current_ua  = UpdateCurrentRst;
      phase_q  = PhaseCodeActive;
      short_ms = '0;
      long_ms  = '0;
      updates  = '0;
      expected_results.delete();
      pending_o = 0;
      fails_o   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[CfgAddrBits-1:AddrLsb])
          RegActiveTimer:    cfg.active_timer_ms    = pwdata_i[TimeBits-1:0];
          RegPeriodicUpdate: cfg.periodic_update_ms = pwdata_i[TimeBits-1:0];
          RegUpdateDuration: cfg.update_duration_ms = pwdata_i[TimeBits-1:0];
          RegSleepCurrent:   cfg.doze_current_ua    = pwdata_i[CurBits-1:0];
          RegIdleCurrent:    cfg.idle_current_ua    = pwdata_i[CurBits-1:0];
          RegBusyCurrent:    cfg.busy_current_ua    = pwdata_i[CurBits-1:0];
          RegUpdateCurrent:  cfg.update_current_ua  = pwdata_i[CurBits-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(advance_phase(in_data_i.dt_ms));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fails_o++;
          if (fails_o <= 10) begin
            $display("%0t: unexpected result phase %0d current %0d updates %0d", $realtime,
                     out_data_i.phase_out, out_data_i.current_ua, out_data_i.update_total);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.phase_out !== want.phase_out ||
              out_data_i.current_ua !== want.current_ua ||
              out_data_i.update_total !== want.update_total) begin
            fails_o++;
            if (fails_o <= 10) begin
              $display("%0t: mismatch expected phase %0d current %0d updates %0d", $realtime,
                       want.phase_out, want.current_ua, want.update_total);
              $display("%0t:            got phase %0d current %0d updates %0d", $realtime,
                       out_data_i.phase_out, out_data_i.current_ua, out_data_i.update_total);
            end
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import psm_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int MaxCurrent    = 20'hFFFFF;
  localparam logic [RegIdxBits-1:0] RegUnused = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CfgAddrBits-1:0] paddr;
  logic [CfgDataBits-1:0] pwdata;
  logic [CfgDataBits-1:0] prdata;
  logic                   pready;

  int   pending;
  int   fails;
  int   gap_pct;
  int   stall_pct;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  logic calm;

  logic [DtBits-1:0] opening_ticks [20] = '{
    32'd0, 32'hFFFF_FFFF, 32'd0, 32'd9999, 32'd0, 32'd1, 32'd86389999, 32'd0,
    32'd1, 32'd1999, 32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
  };

  psm_in_if  in_ch ();
  psm_out_if out_ch ();

  psm_timer_state_machine_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  psm_result_checker result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .fails_o     (fails)
  );

  always #5 clk_i = ~clk_i;

  // output stalls in bursts
  always @(negedge clk_i) begin
    if (calm || stall_pct == 0) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic [DtBits-1:0] dt);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.dt_ms <= dt;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // leaves psel high so writes can follow back to back
  task automatic write_reg(input logic [RegIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {AddrLsb{1'b0}}};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  // junk above the register width must be dropped
  function automatic logic [CfgDataBits-1:0] pad_junk(input logic [CfgDataBits-1:0] value,
                                                      input int width);
    return ({$urandom, $urandom} << width) | value;
  endfunction

  task automatic program_regs(input logic [CfgDataBits-1:0] act_ms, per_ms, dur_ms,
                              input logic [CfgDataBits-1:0] sleep_ua, idle_ua, busy_ua,
                              input logic [CfgDataBits-1:0] upd_ua);
    write_reg(RegActiveTimer, pad_junk(act_ms, TimeBits));
    write_reg(RegPeriodicUpdate, pad_junk(per_ms, TimeBits));
    write_reg(RegUpdateDuration, pad_junk(dur_ms, TimeBits));
    write_reg(RegSleepCurrent, pad_junk(sleep_ua, CurBits));
    write_reg(RegIdleCurrent, pad_junk(idle_ua, CurBits));
    write_reg(RegBusyCurrent, pad_junk(busy_ua, CurBits));
    write_reg(RegUpdateCurrent, pad_junk(upd_ua, CurBits));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_small();
    program_regs(CfgDataBits'($urandom_range(1, 300)), CfgDataBits'($urandom_range(1, 1000)),
                 CfgDataBits'($urandom_range(1, 200)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)));
  endtask

  task automatic run_ticks(input int count, input logic [DtBits-1:0] span);
    int pause_at;
    logic [DtBits-1:0] dt;
    pause_at = $urandom_range(1, count - 1);
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) settle();
      case ($urandom_range(0, 9))
        0:       dt = '0;
        1:       dt = $urandom;
        default: dt = $urandom_range(1, span);
      endcase
      send_tick(dt);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    gap_pct      = 30;
    stall_pct    = 30;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: walk every phase transition by hand
    foreach (opening_ticks[k]) send_tick(opening_ticks[k]);

    settle();
    program_small();
    run_ticks(200, 100);

    // all limits zero, every nonzero tick moves on
    settle();
    gap_pct   = 10;
    stall_pct = 10;
    write_reg(RegUnused, '1);
    program_regs('0, '0, '0, '0, '0, '0, '0);
    run_ticks(100, '1);

    settle();
    gap_pct   = 20;
    stall_pct = 40;
    program_regs('1, '1, '1, '1, '1, '1, '1);
    run_ticks(150, '1);

    settle();
    gap_pct   = 0;
    stall_pct = 0;
    program_regs(CfgDataBits'($urandom_range(1, 1 << 20)),
                 CfgDataBits'($urandom_range(1, 1 << 21)),
                 CfgDataBits'($urandom_range(1, 1 << 16)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)),
                 CfgDataBits'($urandom_range(0, MaxCurrent)));
    run_ticks(150, 32'h1_0000);

    settle();
    calm = 1'b1;
    program_small();
    run_ticks(150, 100);

    settle();
    repeat (4) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
